// File: rtl/scs_pkg.sv
// Package: types and constants for the sterilizer cycle sequencer.
`timescale 1ns / 1ps
package scs_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int TEMP_SCALE = 500;
   localparam int PROD_BITS = SAMPLE_BITS + 9;

   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 12;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MINUTES_A = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MINUTES_B = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MINUTES_C = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TICKS_PER_MIN = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEAT_DONE = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COOL_DONE = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNLOAD_WAIT = 3'd6;

   typedef enum logic [3:0] {
      PH_SELECT     = 4'd0,
      PH_FILL       = 4'd1,
      PH_OPEN       = 4'd2,
      PH_LOAD       = 4'd3,
      PH_CLOSE      = 4'd4,
      PH_PURGE      = 4'd5,
      PH_STERILIZE  = 4'd6,
      PH_VENT       = 4'd7,
      PH_REOPEN     = 4'd8,
      PH_UNLOAD     = 4'd9,
      PH_DONE       = 4'd10
   } phase_type;

   typedef struct packed {
      logic                   press_a;
      logic                   press_b;
      logic                   press_c;
      logic                   water_full;
      logic                   door_fully_open;
      logic                   door_fully_shut;
      logic                   close_request;
      logic [SAMPLE_BITS-1:0] temp_sample;
   } scs_req_type;

   typedef struct packed {
      logic        pump_on;
      logic        purge_open;
      logic        heater_on;
      logic        motor_opening;
      logic        motor_closing;
      logic [3:0]  phase;
      logic [7:0]  minutes_left;
      logic [11:0] wait_ticks_left;
      logic [8:0]  temp_celsius;
   } scs_rsp_type;

endpackage

// File: rtl/sterilizer_cycle_sequencer.sv
// Top level: sterilizer cycle sequencer, one request per timer tick.
//
// Usage: each request on req_* is one 100 ms tick carrying buttons, limit
// switches, the water-level switch and a temperature sample. Each request
// yields exactly one response on rsp_* with the drive outputs, the phase
// reached, minutes left, unload wait ticks left and the temperature in C.
// Requests pass an input register, then one stage of phase and counter
// logic into the response register; rsp_valid rises when the request moves on
// into the response register. Throughput is one request per cycle unless the
// receiver stalls, set by the single registered pass through the phase logic.
// When the receiver stalls, the response register holds and the input
// register still takes one more request; req_ready drops once both are full.
// csr_* writes one of the seven setting registers per cycle, without handshake.
// Synchronous reset returns the phase to select, clears the counters and
// loads the default settings; no response is pending after reset.
`timescale 1ns / 1ps
module sterilizer_cycle_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  scs_pkg::scs_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output scs_pkg::scs_rsp_type                rsp_data,
   input  logic                                csr_we,
   input  logic [scs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [scs_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import scs_pkg::*;

   // settings
   logic [7:0]             min_a_ff, min_b_ff, min_c_ff;
   logic [11:0]            tpm_ff;
   logic [SAMPLE_BITS-1:0] heat_ff, cool_ff;
   logic [11:0]            uwt_ff;

   // pipeline
   logic        s1_valid_ff;
   scs_req_type s1_data_ff;
   logic        out_valid_ff;
   scs_rsp_type out_data_ff;
   logic        advance;

   // sequencer state
   phase_type   phase_ff, phase_in;
   logic [7:0]  chosen_ff, chosen_in;
   logic [11:0] tick_ff, tick_in;
   logic [7:0]  elapsed_ff, elapsed_in;
   logic [11:0] unload_ff, unload_in;
   scs_rsp_type rsp_in;

   logic [11:0]          tick_inc;
   logic [11:0]          unload_inc;
   logic [PROD_BITS-1:0] temp_prod;

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_a_ff <= 8'd15;
         min_b_ff <= 8'd20;
         min_c_ff <= 8'd45;
         tpm_ff   <= 12'd600;
         heat_ff  <= SAMPLE_BITS'(248);
         cool_ff  <= SAMPLE_BITS'(61);
         uwt_ff   <= 12'd600;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MINUTES_A:     min_a_ff <= csr_wdata[7:0];
            CSR_MINUTES_B:     min_b_ff <= csr_wdata[7:0];
            CSR_MINUTES_C:     min_c_ff <= csr_wdata[7:0];
            CSR_TICKS_PER_MIN: tpm_ff   <= csr_wdata[11:0];
            CSR_HEAT_DONE:     heat_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_COOL_DONE:     cool_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_UNLOAD_WAIT:   uwt_ff   <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         s1_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_SELECT;
         chosen_ff    <= 8'd0;
         tick_ff      <= 12'd0;
         elapsed_ff   <= 8'd0;
         unload_ff    <= 12'd0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            chosen_ff    <= chosen_in;
            tick_ff      <= tick_in;
            elapsed_ff   <= elapsed_in;
            unload_ff    <= unload_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_data_ff <= rsp_in;
      end
   end

   assign tick_inc   = tick_ff + 12'd1;
   assign unload_inc = unload_ff + 12'd1;
   assign temp_prod  = PROD_BITS'(s1_data_ff.temp_sample) * PROD_BITS'(TEMP_SCALE);

   always_comb begin
      phase_in   = phase_ff;
      chosen_in  = chosen_ff;
      tick_in    = tick_ff;
      elapsed_in = elapsed_ff;
      unload_in  = unload_ff;
      case (phase_ff)
         PH_SELECT: begin
            if (s1_data_ff.press_c) begin
               chosen_in = min_c_ff;
               phase_in  = PH_FILL;
            end else if (s1_data_ff.press_b) begin
               chosen_in = min_b_ff;
               phase_in  = PH_FILL;
            end else if (s1_data_ff.press_a) begin
               chosen_in = min_a_ff;
               phase_in  = PH_FILL;
            end
         end
         PH_FILL: begin
            if (s1_data_ff.water_full) phase_in = PH_OPEN;
         end
         PH_OPEN: begin
            if (s1_data_ff.door_fully_open) phase_in = PH_LOAD;
         end
         PH_LOAD: begin
            if (s1_data_ff.close_request) phase_in = PH_CLOSE;
         end
         PH_CLOSE: begin
            if (s1_data_ff.door_fully_shut) phase_in = PH_PURGE;
         end
         PH_PURGE: begin
            if (s1_data_ff.temp_sample >= heat_ff) begin
               phase_in   = PH_STERILIZE;
               tick_in    = 12'd0;
               elapsed_in = 8'd0;
            end
         end
         PH_STERILIZE: begin
            tick_in = tick_inc;
            if (tick_inc >= tpm_ff) begin
               tick_in    = 12'd0;
               elapsed_in = elapsed_ff + 8'd1;
            end
            if (elapsed_in >= chosen_ff) phase_in = PH_VENT;
         end
         PH_VENT: begin
            if (s1_data_ff.temp_sample <= cool_ff) phase_in = PH_REOPEN;
         end
         PH_REOPEN: begin
            if (s1_data_ff.door_fully_open) begin
               phase_in  = PH_UNLOAD;
               unload_in = 12'd0;
            end
         end
         PH_UNLOAD: begin
            unload_in = unload_inc;
            if (unload_inc >= uwt_ff) phase_in = PH_DONE;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_in.pump_on       = (phase_in == PH_FILL);
      rsp_in.purge_open    = (phase_in == PH_PURGE) || (phase_in == PH_VENT);
      rsp_in.heater_on     = (phase_in == PH_PURGE) || (phase_in == PH_STERILIZE);
      rsp_in.motor_opening = (phase_in == PH_OPEN) || (phase_in == PH_REOPEN);
      rsp_in.motor_closing = (phase_in == PH_CLOSE);
      rsp_in.phase         = phase_in;
      rsp_in.minutes_left  = 8'd0;
      if ((phase_in == PH_STERILIZE) && (chosen_in >= elapsed_in)) begin
         rsp_in.minutes_left = chosen_in - elapsed_in;
      end
      rsp_in.wait_ticks_left = 12'd0;
      if ((phase_in == PH_UNLOAD) && (uwt_ff >= unload_in)) begin
         rsp_in.wait_ticks_left = uwt_ff - unload_in;
      end
      rsp_in.temp_celsius = temp_prod[PROD_BITS-1:SAMPLE_BITS];
   end

endmodule
